// ===== hdl/frt_pkg.sv =====
// Shared types and constants of the fragment reassembly tracker.
// Used by frt_window and the top module; depends on nothing.
package frt_pkg;

    localparam int SEQ_SPACE       = 256;
    localparam int SEQ_W           = $clog2(SEQ_SPACE);
    localparam int MAX_PIECES      = 32;
    localparam int SIZE_ROUND_BITS = 2;
    localparam int HEADER_BYTES    = 4;

    localparam int LEN_W      = 16;
    localparam int KIND_W     = 2;
    localparam int IDX_W      = 5;
    localparam int OFFS_W     = 21;
    localparam int STATUS_W   = 4;
    localparam int SLOT_OUT_W = 4;

    localparam logic [LEN_W-1:0] CAP_RESET = 16'd1536;

    localparam logic [MAX_PIECES-1:0] PIECE_MAP_FULL = {MAX_PIECES{1'b1}};
    localparam logic [LEN_W-1:0] SIZE_ALIGN_MASK = LEN_W'((1 << SIZE_ROUND_BITS) - 1);

    localparam logic [KIND_W-1:0] KIND_WHOLE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MID   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LAST  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_TEST  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_EMPTY     = 4'd0;
    localparam logic [STATUS_W-1:0] ST_WHOLE     = 4'd1;
    localparam logic [STATUS_W-1:0] ST_PARTIAL   = 4'd2;
    localparam logic [STATUS_W-1:0] ST_COMPLETE  = 4'd3;
    localparam logic [STATUS_W-1:0] ST_SHORT     = 4'd4;
    localparam logic [STATUS_W-1:0] ST_SPURIOUS  = 4'd5;
    localparam logic [STATUS_W-1:0] ST_BAD_SIZE  = 4'd6;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 4'd7;
    localparam logic [STATUS_W-1:0] ST_TEST      = 4'd8;

    typedef struct packed {
        logic [LEN_W-1:0]  datagram_len;
        logic [KIND_W-1:0] frag_kind;
        logic [SEQ_W-1:0]  seq_number;
        logic [IDX_W-1:0]  frag_index;
        logic [LEN_W-1:0]  peer_frag_size;
    } frt_in_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [SLOT_OUT_W-1:0] slot;
        logic [OFFS_W-1:0]     write_offset;
        logic [LEN_W-1:0]      complete_len;
        logic [LEN_W-1:0]      max_payload_seen;
        logic [LEN_W-1:0]      max_size_confirmed;
    } frt_out_t;

    typedef struct packed {
        logic [LEN_W-1:0]      piece_size;
        logic [MAX_PIECES-1:0] bitmap;
        logic [LEN_W-1:0]      length;
    } slot_entry_t;

    typedef struct packed {
        logic             pick;
        logic [SEQ_W-1:0] seq;
    } win_pick_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PICK,
        S_READ,
        S_UPD,
        S_OUT
    } frt_state_t;

endpackage

// ===== hdl/frt_sdp_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module frt_sdp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/frt_window.sv =====
// Sliding window of reassembly slots: base sequence, head slot and per-slot valid bits.
// Depends on frt_pkg.
module frt_window
    import frt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  win_pick_t                pick_i,
    output logic [$clog2(SLOTS)-1:0] slot_o,
    input  logic                     upd_en_i,
    input  logic [$clog2(SLOTS)-1:0] upd_slot_i,
    input  logic                     upd_valid_i,
    output logic                     chk_valid_o
);

    localparam int SLOT_W = $clog2(SLOTS);
    localparam logic signed [SEQ_W:0] SLOTS_S = (SEQ_W+1)'(SLOTS);

    logic [SEQ_W-1:0]        base_reg;
    logic [SLOT_W-1:0]       head_reg;
    logic [SLOTS-1:0]        valid_reg;

    logic [SEQ_W-1:0]        diff;
    logic signed [SEQ_W:0]   dist_x;
    logic signed [SEQ_W:0]   neg_x;
    logic                    far;
    logic                    adv;
    logic [SLOT_W-1:0]       steps;
    logic [SLOT_W-1:0]       back;
    logic [SLOT_W:0]         head_sum;
    logic [SLOT_W-1:0]       head_next;
    logic [SLOT_W:0]         back_sum;
    logic [SLOT_W-1:0]       back_slot;
    logic [SLOTS-1:0]        clr_mask;
    logic [SLOT_W:0]         rel [SLOTS];

    assign diff   = pick_i.seq - base_reg;
    assign dist_x = signed'({diff[SEQ_W-1], diff});
    assign neg_x  = -dist_x;
    assign far    = (dist_x >= SLOTS_S) || (dist_x <= -SLOTS_S);
    assign adv    = !far && (dist_x > 0);
    assign steps  = dist_x[SLOT_W-1:0];
    assign back   = neg_x[SLOT_W-1:0];

    always_comb begin
        head_sum = {1'b0, head_reg} + {1'b0, steps};
        if (head_sum >= (SLOT_W+1)'(SLOTS)) begin
            head_sum = head_sum - (SLOT_W+1)'(SLOTS);
        end
        head_next = head_sum[SLOT_W-1:0];

        back_sum = {1'b0, head_reg} + (SLOT_W+1)'(SLOTS) - {1'b0, back};
        if (back_sum >= (SLOT_W+1)'(SLOTS)) begin
            back_sum = back_sum - (SLOT_W+1)'(SLOTS);
        end
        back_slot = back_sum[SLOT_W-1:0];
    end

    // Slot i is passed by the advance when its distance past the head is 1..steps.
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            rel[i] = (SLOT_W+1)'(i) + (SLOT_W+1)'(SLOTS - 1) - {1'b0, head_reg};
            if (rel[i] >= (SLOT_W+1)'(SLOTS)) begin
                rel[i] = rel[i] - (SLOT_W+1)'(SLOTS);
            end
            clr_mask[i] = (rel[i] < {1'b0, steps});
        end
    end

    always_comb begin
        if (far) begin
            slot_o = '0;
        end else if (adv) begin
            slot_o = head_next;
        end else begin
            slot_o = back_slot;
        end
    end

    assign chk_valid_o = valid_reg[upd_slot_i];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_reg  <= '0;
            head_reg  <= '0;
            valid_reg <= '0;
        end else begin
            if (pick_i.pick) begin
                if (far) begin
                    valid_reg <= '0;
                    head_reg  <= '0;
                    base_reg  <= pick_i.seq;
                end else if (adv) begin
                    valid_reg <= valid_reg & ~clr_mask;
                    head_reg  <= head_next;
                    base_reg  <= pick_i.seq;
                end
            end
            if (upd_en_i) begin
                valid_reg[upd_slot_i] <= upd_valid_i;
            end
        end
    end

endmodule

// ===== hdl/fragment_reassembly_tracker_top.sv =====
// Fragment reassembly tracker: empty, short, whole and test datagrams go from the input beat
// through the pick state to the output register; fragments go through pick, read and update,
// a read-modify-write of the slot RAM (read, then write); one item is in flight at a time.
// A finished result waits in the output register while the next beat is accepted.
// Synchronous active-low reset clears window, valid bits, maxima and sets capacity to 1536;
// the slot RAM is not cleared and needs no clearing pass.
// Depends on frt_pkg, frt_sdp_ram and frt_window.
module fragment_reassembly_tracker_top
    import frt_pkg::*;
#(
    parameter int SLOTS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  frt_in_t          s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output frt_out_t         m_data,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [LEN_W-1:0] cfg_data
);

    localparam int SLOT_W = $clog2(SLOTS);

    frt_state_t         state_reg, state_next;
    frt_in_t            in_reg;
    logic [LEN_W-1:0]   cap_reg;
    logic [LEN_W-1:0]   pmax_reg;
    logic [LEN_W-1:0]   cmax_reg;
    logic [SLOT_W-1:0]  slot_reg;
    logic [LEN_W-1:0]   size_reg;
    logic [LEN_W-1:0]   payload_reg;
    logic [OFFS_W-1:0]  offset_reg;
    frt_out_t           res_reg;
    frt_out_t           m_data_reg;
    logic               m_valid_reg;

    logic               empty, short_hdr, frag_go, is_kind_frag;
    logic [LEN_W-1:0]   payload;
    logic [STATUS_W-1:0] pick_status;

    win_pick_t          pick;
    logic [SLOT_W-1:0]  win_slot;
    logic               chk_valid;
    logic               upd_en, upd_valid;

    logic               ram_wr_en, ram_rd_en;
    slot_entry_t        ram_q, ram_wdata;

    logic               bad_size, fresh, ovf, full;
    slot_entry_t        base_e;
    logic [OFFS_W:0]    end_sum;
    logic [MAX_PIECES-1:0] new_bits, new_map;
    logic [LEN_W-1:0]   new_len;
    logic [STATUS_W-1:0] upd_status;
    logic               out_load;

    // ---------------- decode of the held beat ----------------
    assign empty        = (in_reg.datagram_len == '0);
    assign short_hdr    = !empty && (in_reg.datagram_len < LEN_W'(HEADER_BYTES));
    assign payload      = in_reg.datagram_len - LEN_W'(HEADER_BYTES);
    assign is_kind_frag = (in_reg.frag_kind == KIND_MID) || (in_reg.frag_kind == KIND_LAST);
    assign frag_go      = !empty && !short_hdr && is_kind_frag;

    always_comb begin
        if (empty) begin
            pick_status = ST_EMPTY;
        end else if (short_hdr) begin
            pick_status = ST_SHORT;
        end else if (in_reg.frag_kind == KIND_WHOLE) begin
            pick_status = ((in_reg.seq_number != '0) || (in_reg.frag_index != '0)) ?
                          ST_SPURIOUS : ST_WHOLE;
        end else begin
            pick_status = ST_TEST;
        end
    end

    // ---------------- slot update ----------------
    assign bad_size = |(size_reg & SIZE_ALIGN_MASK);
    assign fresh    = !chk_valid || (ram_q.piece_size != size_reg);

    always_comb begin
        if (fresh) begin
            base_e.piece_size = size_reg;
            base_e.bitmap     = '0;
            base_e.length     = '0;
        end else begin
            base_e = ram_q;
        end
    end

    assign end_sum = (OFFS_W+1)'(offset_reg) + (OFFS_W+1)'(payload_reg);
    assign ovf     = end_sum > (OFFS_W+1)'(cap_reg);

    // A last fragment sets its own bit and every higher bit.
    assign new_bits = (in_reg.frag_kind == KIND_LAST) ? (PIECE_MAP_FULL << in_reg.frag_index)
                                                      : (MAX_PIECES'(1) << in_reg.frag_index);
    assign new_map  = base_e.bitmap | new_bits;
    assign full     = (new_map == PIECE_MAP_FULL);
    assign new_len  = (end_sum[LEN_W-1:0] > base_e.length) ? end_sum[LEN_W-1:0] : base_e.length;

    always_comb begin
        if (bad_size) begin
            upd_status = ST_BAD_SIZE;
        end else if (ovf) begin
            upd_status = ST_OVERFLOW;
        end else if (full) begin
            upd_status = ST_COMPLETE;
        end else begin
            upd_status = ST_PARTIAL;
        end
    end

    always_comb begin
        if (ovf) begin
            ram_wdata = base_e;
        end else begin
            ram_wdata.piece_size = size_reg;
            ram_wdata.bitmap     = new_map;
            ram_wdata.length     = new_len;
        end
    end

    // ---------------- next state ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_PICK;
                end
            end
            S_PICK: begin
                state_next = frag_go ? S_READ : S_OUT;
            end
            S_READ: begin
                state_next = S_UPD;
            end
            S_UPD: begin
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // ---------------- state outputs ----------------
    always_comb begin
        s_ready   = 1'b0;
        ram_rd_en = 1'b0;
        ram_wr_en = 1'b0;
        upd_en    = 1'b0;
        upd_valid = 1'b0;
        out_load  = 1'b0;
        pick.pick = 1'b0;
        pick.seq  = in_reg.seq_number;
        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
            end
            S_PICK: begin
                pick.pick = frag_go;
                ram_rd_en = frag_go;
            end
            S_READ: begin
            end
            S_UPD: begin
                ram_wr_en = !bad_size;
                upd_en    = !bad_size;
                upd_valid = ovf || !full;
            end
            S_OUT: begin
                out_load = !m_valid_reg || m_ready;
            end
            default: begin
            end
        endcase
    end

    assign cfg_ready = 1'b1;

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            cap_reg     <= CAP_RESET;
            pmax_reg    <= '0;
            cmax_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                cap_reg <= cfg_data;
            end
            if (state_reg == S_PICK && !empty && !short_hdr) begin
                if (payload > pmax_reg) begin
                    pmax_reg <= payload;
                end
                if (((in_reg.frag_kind == KIND_WHOLE) || (in_reg.frag_kind == KIND_MID))
                    && (in_reg.peer_frag_size > cmax_reg)) begin
                    cmax_reg <= in_reg.peer_frag_size;
                end
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
        if (state_reg == S_PICK) begin
            res_reg.status       <= pick_status;
            res_reg.slot         <= frag_go ? SLOT_OUT_W'(win_slot) : '0;
            res_reg.write_offset <= '0;
            res_reg.complete_len <= '0;
            slot_reg             <= win_slot;
            size_reg             <= (in_reg.frag_kind == KIND_LAST) ? in_reg.peer_frag_size
                                                                    : payload;
            payload_reg          <= payload;
        end
        if (state_reg == S_READ) begin
            offset_reg <= OFFS_W'(in_reg.frag_index) * OFFS_W'(size_reg);
        end
        if (state_reg == S_UPD) begin
            res_reg.status       <= upd_status;
            res_reg.write_offset <= bad_size ? '0 : offset_reg;
            res_reg.complete_len <= (!bad_size && !ovf && full) ? new_len : '0;
        end
        if (out_load) begin
            m_data_reg <= '{status:             res_reg.status,
                            slot:               res_reg.slot,
                            write_offset:       res_reg.write_offset,
                            complete_len:       res_reg.complete_len,
                            max_payload_seen:   pmax_reg,
                            max_size_confirmed: cmax_reg};
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- submodules ----------------
    frt_window #(
        .SLOTS (SLOTS)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pick_i      (pick),
        .slot_o      (win_slot),
        .upd_en_i    (upd_en),
        .upd_slot_i  (slot_reg),
        .upd_valid_i (upd_valid),
        .chk_valid_o (chk_valid)
    );

    frt_sdp_ram #(
        .WIDTH ($bits(slot_entry_t)),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_reg),
        .wr_data (ram_wdata),
        .rd_en   (ram_rd_en),
        .rd_addr (win_slot),
        .rd_data (ram_q)
    );

endmodule
